[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MSP_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define MSP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/msp_pkg.sv]
// Shared constants, types and helper functions of the saddle point finder.
// No dependencies.
`timescale 1ns / 1ps

package msp_pkg;

   localparam int MAX_ROWS  = 8;
   localparam int MAX_COLS  = 8;
   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W    = 16;
   localparam int SIZE_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_ROW_W = 3;
   localparam int OUT_COL_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 2'd1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_READ,
      ST_CHECK,
      ST_RESULT
   } state_type;

   // Last row index in use: zero counts as one row, large values saturate.
   function automatic logic [ROW_W-1:0] row_last(input logic [SIZE_W-1:0] v);
      logic [ROW_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (32'(v) > MAX_ROWS) begin
         res = ROW_W'(MAX_ROWS - 1);
      end else begin
         res = ROW_W'(v - 1'b1);
      end
      return res;
   endfunction

   function automatic logic [COL_W-1:0] col_last(input logic [SIZE_W-1:0] v);
      logic [COL_W-1:0] res;
      if (v == '0) begin
         res = '0;
      end else if (32'(v) > MAX_COLS) begin
         res = COL_W'(MAX_COLS - 1);
      end else begin
         res = COL_W'(v - 1'b1);
      end
      return res;
   endfunction

endpackage

[hw/rtl/msp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msp_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/matrix_saddle_point_finder.sv]
// Saddle point finder: loads a matrix one element per cycle (ready between jobs).
// After the last element of an R x C job the stored matrix is scanned in row-major
// order, each element with a RAM read state, then a compare state, until the first hit or the end.
// A job loads R*C elements, searches, then hands off its result; one RAM port sets the scan.
// Synchronous reset: sizes 8x8, job counters cleared, matrix memory left uninitialized.
`timescale 1ns / 1ps

module matrix_saddle_point_finder (
   input  logic                                       clock,
   input  logic                                       reset,
   // element input
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [msp_pkg::DATA_W-1:0]          req_element_value,
   // result output
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_found,
   output logic signed [msp_pkg::DATA_W-1:0]          rsp_saddle_value,
   output logic        [msp_pkg::OUT_ROW_W-1:0]       rsp_saddle_row,
   output logic        [msp_pkg::OUT_COL_W-1:0]       rsp_saddle_col,
   // configuration writes
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [msp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic        [msp_pkg::SIZE_W-1:0]          csr_data
);

   import msp_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [ROW_W-1:0]  r_last;
   logic [COL_W-1:0]  c_last;

   logic [ROW_W-1:0]  ld_row_ff;
   logic [COL_W-1:0]  ld_col_ff;
   logic [ADDR_W-1:0] ld_addr_ff;
   logic [ROW_W-1:0]  sc_row_ff;
   logic [COL_W-1:0]  sc_col_ff;
   logic [ADDR_W-1:0] sc_addr_ff;

   logic signed [DATA_W-1:0] run_min_ff;
   logic signed [DATA_W-1:0] row_min_ff [MAX_ROWS];
   logic signed [DATA_W-1:0] col_max_ff [MAX_COLS];

   logic                     res_found_ff;
   logic signed [DATA_W-1:0] res_value_ff;
   logic [OUT_ROW_W-1:0]     res_row_ff;
   logic [OUT_COL_W-1:0]     res_col_ff;

   logic                     req_acc, csr_acc, csr_hit;
   logic                     ld_last_col, ld_last_row, ld_last;
   logic                     sc_last_col, sc_last_row, sc_last;
   logic [COL_W-1:0]         cm_idx;
   logic signed [DATA_W-1:0] cm_rd;
   logic signed [DATA_W-1:0] new_min, new_max;
   logic signed [DATA_W-1:0] mem_rd;
   logic                     hit;

   assign r_last = row_last(rows_cfg_ff);
   assign c_last = col_last(cols_cfg_ff);

   // ---------------------------------------------------------------- handshakes
   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            csr_ready = 1'b1;
         end
         ST_RESULT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   assign req_acc = req_valid && !req_stall;
   assign csr_acc = csr_valid && csr_ready;
   assign csr_hit = csr_acc && (csr_index inside {CSR_ROWS_IN_USE, CSR_COLS_IN_USE});

   assign ld_last_col = (ld_col_ff == c_last);
   assign ld_last_row = (ld_row_ff == r_last);
   assign ld_last     = ld_last_col && ld_last_row;
   assign sc_last_col = (sc_col_ff == c_last);
   assign sc_last_row = (sc_row_ff == r_last);
   assign sc_last     = sc_last_col && sc_last_row;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:   if (req_acc && !csr_hit && ld_last) state_in = ST_READ;
         ST_READ:   state_in = ST_CHECK;
         ST_CHECK:  state_in = (hit || sc_last) ? ST_RESULT : ST_READ;
         ST_RESULT: if (!rsp_stall) state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   // ---------------------------------------------------------------- load path
   // One compare unit keeps the running row minimum, one the column maximum.
   assign cm_idx  = (state_ff == ST_LOAD) ? ld_col_ff : sc_col_ff;
   assign cm_rd   = col_max_ff[cm_idx];
   assign new_min = (ld_col_ff == '0 || req_element_value < run_min_ff)
                    ? req_element_value : run_min_ff;
   assign new_max = (ld_row_ff == '0 || req_element_value > cm_rd)
                    ? req_element_value : cm_rd;

   msp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_mem (
      .clock  (clock),
      .wr_en  (req_acc),
      .wr_addr(ld_addr_ff),
      .wr_data(req_element_value),
      .rd_addr(sc_addr_ff),
      .rd_data(mem_rd)
   );

   // Element is a saddle point iff it equals both its row minimum and column maximum.
   assign hit = (mem_rd == row_min_ff[sc_row_ff]) && (mem_rd == cm_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         rows_cfg_ff <= SIZE_W'(MAX_ROWS);
         cols_cfg_ff <= SIZE_W'(MAX_COLS);
         ld_row_ff   <= '0;
         ld_col_ff   <= '0;
         ld_addr_ff  <= '0;
         sc_row_ff   <= '0;
         sc_col_ff   <= '0;
         sc_addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_hit) begin
            if (csr_index == CSR_ROWS_IN_USE) begin
               rows_cfg_ff <= csr_data;
            end else begin
               cols_cfg_ff <= csr_data;
            end
            ld_row_ff  <= '0;
            ld_col_ff  <= '0;
            ld_addr_ff <= '0;
         end else if (req_acc) begin
            if (ld_last_col) begin
               ld_col_ff <= '0;
               if (ld_last_row) begin
                  ld_row_ff  <= '0;
                  ld_addr_ff <= '0;
               end else begin
                  ld_row_ff  <= ld_row_ff + 1'b1;
                  ld_addr_ff <= ld_addr_ff + 1'b1;
               end
            end else begin
               ld_col_ff  <= ld_col_ff + 1'b1;
               ld_addr_ff <= ld_addr_ff + 1'b1;
            end
         end
         if (state_ff == ST_LOAD) begin
            sc_row_ff  <= '0;
            sc_col_ff  <= '0;
            sc_addr_ff <= '0;
         end else if (state_ff == ST_CHECK && !hit && !sc_last) begin
            if (sc_last_col) begin
               sc_col_ff <= '0;
               sc_row_ff <= sc_row_ff + 1'b1;
            end else begin
               sc_col_ff <= sc_col_ff + 1'b1;
            end
            sc_addr_ff <= sc_addr_ff + 1'b1;
         end
      end
   end

   // Datapath registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         run_min_ff          <= new_min;
         col_max_ff[cm_idx]  <= new_max;
         if (ld_last_col) begin
            row_min_ff[ld_row_ff] <= new_min;
         end
      end
      if (state_ff == ST_CHECK) begin
         if (hit) begin
            res_found_ff <= 1'b1;
            res_value_ff <= mem_rd;
            res_row_ff   <= OUT_ROW_W'(sc_row_ff);
            res_col_ff   <= OUT_COL_W'(sc_col_ff);
         end else begin
            res_found_ff <= 1'b0;
            res_value_ff <= '0;
            res_row_ff   <= '0;
            res_col_ff   <= '0;
         end
      end
   end

   assign rsp_found        = res_found_ff;
   assign rsp_saddle_value = res_value_ff;
   assign rsp_saddle_row   = res_row_ff;
   assign rsp_saddle_col   = res_col_ff;

endmodule

[hw/rtl/msp_checker.sv]
// Port-level assertion checker for the saddle point finder, bound to the top level.
// Depends on msp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic signed [msp_pkg::DATA_W-1:0]    req_element_value,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_found,
   input logic signed [msp_pkg::DATA_W-1:0]    rsp_saddle_value,
   input logic        [msp_pkg::OUT_ROW_W-1:0] rsp_saddle_row,
   input logic        [msp_pkg::OUT_COL_W-1:0] rsp_saddle_col,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic        [msp_pkg::CSR_IDX_W-1:0] csr_index,
   input logic        [msp_pkg::SIZE_W-1:0]    csr_data
);

   import msp_pkg::*;

   // no new elements and no register writes while a result is pending
   `MSP_ASSERT_IMPL(a_busy_while_rsp, clock, reset, rsp_valid, req_stall && !csr_ready)

   // a miss reports all-zero coordinates and value
   `MSP_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_saddle_value == '0 && rsp_saddle_row == '0 && rsp_saddle_col == '0)

   // a result never directly follows an accepted element; the search states come between
   `MSP_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !rsp_valid)

   // stalled result transaction holds
   `MSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_saddle_value) && $stable(rsp_saddle_row) && $stable(rsp_saddle_col))

endmodule

bind matrix_saddle_point_finder msp_checker u_msp_checker (.*);
